@@ src/abhw_pkg.sv @@
// shared types and constants of the archive block header walker
package abhw_pkg;

  localparam int CNT_W = 34;

  localparam int FQ_DEPTH = 2;
  localparam int FQ_PTR_W = $clog2(FQ_DEPTH);
  localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);

  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  localparam logic [7:0]       FILE_BLOCK_TYPE = 8'h74;
  localparam logic [CNT_W-1:0] MARKER_LEN      = CNT_W'(7);
  localparam logic [CNT_W-1:0] HEADER_LEN      = CNT_W'(7);
  localparam logic [CNT_W-1:0] FILE_HEAD_LEN   = CNT_W'(25);
  localparam logic [CNT_W-1:0] FIXED_LEN       = CNT_W'(32);

  // byte positions inside the block header and the file head
  localparam logic [CNT_W-1:0] HDR_TYPE_POS    = CNT_W'(2);
  localparam logic [CNT_W-1:0] HDR_SIZE_LO_POS = CNT_W'(5);
  localparam logic [CNT_W-1:0] HDR_SIZE_HI_POS = CNT_W'(6);
  localparam logic [CNT_W-1:0] FH_PACKED_END   = CNT_W'(4);
  localparam logic [CNT_W-1:0] FH_NAME_LO_POS  = CNT_W'(19);
  localparam logic [CNT_W-1:0] FH_NAME_HI_POS  = CNT_W'(20);

  localparam logic KIND_NAME  = 1'b0;
  localparam logic KIND_COUNT = 1'b1;

  typedef enum logic [2:0] {
    PH_MARKER,
    PH_HEADER,
    PH_FILEHEAD,
    PH_NAME,
    PH_SKIP
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  name_char;
    logic [15:0] file_number;
    logic        name_end;
    logic [15:0] files_seen;
  } result_t;

  // results produced for one byte, packed from slot 0
  typedef struct packed {
    logic [1:0] num;
    result_t    r0;
    result_t    r1;
  } wr_req_t;

endpackage

@@ src/abhw_front.sv @@
// input byte queue in front of the header parser
module abhw_front import abhw_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push,
  output logic  full,
  input  item_t item_i,
  output logic  item_valid_o,
  input  logic  item_ready_i,
  output item_t item_o
);

  item_t                mem_q [FQ_DEPTH];
  logic [FQ_PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [FQ_PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FQ_CNT_W-1:0]  cnt_q, cnt_d;
  logic                 do_wr, do_rd;

  assign full         = (cnt_q == FQ_CNT_W'(FQ_DEPTH));
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = mem_q[rd_ptr_q];
  assign do_wr        = push && !full;
  assign do_rd        = item_valid_o && item_ready_i;

  always_comb begin
    wr_ptr_d = do_wr ? wr_ptr_q + FQ_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_rd ? rd_ptr_q + FQ_PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + FQ_CNT_W'(do_wr) - FQ_CNT_W'(do_rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

@@ src/abhw_parse.sv @@
// block header walker state machine, one byte per cycle while the result queue has room
module abhw_parse import abhw_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    item_valid_i,
  output logic    item_ready_o,
  input  item_t   item_i,
  input  logic    oq_ready_i,
  output wr_req_t wr_o
);

  phase_e           phase_q, phase_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       block_type_q, block_type_d;
  logic [15:0]      block_size_q, block_size_d;
  logic [31:0]      packed_q, packed_d;
  logic [15:0]      name_len_q, name_len_d;
  logic [15:0]      file_total_q, file_total_d;
  logic [CNT_W-1:0] blk_end_q, blk_end_d;

  logic             take;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] cnt_dec;
  logic             end_of_name;
  logic             leave_en;
  logic [CNT_W-1:0] leave_end;
  logic [CNT_W-1:0] leave_cons;
  logic [CNT_W:0]   leave_diff;
  logic [CNT_W-1:0] leave_rem;
  logic             name_emit;
  logic [15:0]      total_upd;
  result_t          name_res, count_res;

  assign item_ready_o = oq_ready_i;
  assign take         = item_valid_i && oq_ready_i;
  assign cnt_inc      = cnt_q + CNT_W'(1);
  assign cnt_dec      = (cnt_q != '0) ? cnt_q - CNT_W'(1) : cnt_q;
  assign end_of_name  = (cnt_inc >= CNT_W'(name_len_q));

  // remaining bytes of the block, zero when already overrun
  assign leave_diff = {1'b0, leave_end} - {1'b0, leave_cons};
  assign leave_rem  = (leave_diff[CNT_W] || leave_diff == '0) ? '0 : leave_diff[CNT_W-1:0];

  always_comb begin
    phase_d      = phase_q;
    cnt_d        = cnt_q;
    block_type_d = block_type_q;
    block_size_d = block_size_q;
    packed_d     = packed_q;
    name_len_d   = name_len_q;
    file_total_d = file_total_q;
    blk_end_d    = blk_end_q;
    leave_en     = 1'b0;
    leave_end    = '0;
    leave_cons   = '0;
    name_emit    = 1'b0;
    total_upd    = file_total_q;

    if (take) begin
      case (phase_q)
        PH_MARKER: begin
          if (cnt_inc >= MARKER_LEN) begin
            phase_d = PH_HEADER;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_inc;
          end
        end
        PH_HEADER: begin
          if (cnt_q == HDR_TYPE_POS) begin
            block_type_d = item_i.data_byte;
          end else if (cnt_q == HDR_SIZE_LO_POS) begin
            block_size_d[7:0] = item_i.data_byte;
          end else if (cnt_q == HDR_SIZE_HI_POS) begin
            block_size_d[15:8] = item_i.data_byte;
          end
          cnt_d = cnt_inc;
          if (cnt_inc >= HEADER_LEN) begin
            packed_d   = '0;
            name_len_d = '0;
            if (block_type_d == FILE_BLOCK_TYPE) begin
              if (file_total_q != 16'hFFFF) begin
                file_total_d = file_total_q + 16'd1;
              end
              phase_d = PH_FILEHEAD;
              cnt_d   = '0;
            end else begin
              leave_en   = 1'b1;
              leave_end  = CNT_W'(block_size_d);
              leave_cons = HEADER_LEN;
            end
          end
        end
        PH_FILEHEAD: begin
          blk_end_d = CNT_W'(block_size_q) + CNT_W'(packed_q);
          if (cnt_q < FH_PACKED_END) begin
            case (cnt_q[1:0])
              2'd0:    packed_d[7:0]   = item_i.data_byte;
              2'd1:    packed_d[15:8]  = item_i.data_byte;
              2'd2:    packed_d[23:16] = item_i.data_byte;
              default: packed_d[31:24] = item_i.data_byte;
            endcase
          end else if (cnt_q == FH_NAME_LO_POS) begin
            name_len_d[7:0] = item_i.data_byte;
          end else if (cnt_q == FH_NAME_HI_POS) begin
            name_len_d[15:8] = item_i.data_byte;
          end
          cnt_d = cnt_inc;
          if (cnt_inc >= FILE_HEAD_LEN) begin
            if (name_len_d == '0) begin
              leave_en   = 1'b1;
              leave_end  = blk_end_q;
              leave_cons = FIXED_LEN;
            end else begin
              phase_d = PH_NAME;
              cnt_d   = '0;
            end
          end
        end
        PH_NAME: begin
          name_emit = 1'b1;
          cnt_d     = cnt_inc;
          if (end_of_name) begin
            leave_en   = 1'b1;
            leave_end  = blk_end_q;
            leave_cons = FIXED_LEN + CNT_W'(name_len_q);
          end
        end
        PH_SKIP: begin
          cnt_d = cnt_dec;
          if (cnt_dec == '0) begin
            phase_d = PH_HEADER;
          end
        end
        default: begin
          phase_d = PH_HEADER;
          cnt_d   = '0;
        end
      endcase

      if (leave_en) begin
        phase_d = (leave_rem == '0) ? PH_HEADER : PH_SKIP;
        cnt_d   = leave_rem;
      end

      // count as it stands after this byte, before any restart
      total_upd = file_total_d;

      // final byte: back to the reset state for the next archive
      if (item_i.stream_end) begin
        phase_d      = PH_MARKER;
        cnt_d        = '0;
        block_type_d = '0;
        block_size_d = '0;
        packed_d     = '0;
        name_len_d   = '0;
        file_total_d = '0;
      end
    end
  end

  always_comb begin
    name_res.kind        = KIND_NAME;
    name_res.name_char   = item_i.data_byte;
    name_res.file_number = file_total_q;
    name_res.name_end    = end_of_name;
    name_res.files_seen  = file_total_q;

    count_res.kind        = KIND_COUNT;
    count_res.name_char   = '0;
    count_res.file_number = '0;
    count_res.name_end    = 1'b0;
    count_res.files_seen  = total_upd;

    wr_o.num = 2'd0;
    wr_o.r0  = name_res;
    wr_o.r1  = count_res;
    if (take) begin
      if (name_emit) begin
        wr_o.num = item_i.stream_end ? 2'd2 : 2'd1;
      end else if (item_i.stream_end) begin
        wr_o.num = 2'd1;
        wr_o.r0  = count_res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_MARKER;
      cnt_q        <= '0;
      block_type_q <= '0;
      block_size_q <= '0;
      packed_q     <= '0;
      name_len_q   <= '0;
      file_total_q <= '0;
      blk_end_q    <= '0;
    end else begin
      phase_q      <= phase_d;
      cnt_q        <= cnt_d;
      block_type_q <= block_type_d;
      block_size_q <= block_size_d;
      packed_q     <= packed_d;
      name_len_q   <= name_len_d;
      file_total_q <= file_total_d;
      blk_end_q    <= blk_end_d;
    end
  end

`ifndef SYNTHESIS
  a_last_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && item_i.stream_end) |=> (phase_q == PH_MARKER && cnt_q == '0 && file_total_q == '0))
    else $error("walker not back in marker phase after final byte");

  a_skip_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SKIP) |-> (cnt_q != '0))
    else $error("skip phase with nothing left to skip");

  a_name_has_file: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_o.num != 2'd0 && wr_o.r0.kind == KIND_NAME) |-> (wr_o.r0.file_number != '0))
    else $error("name byte emitted before any file block");
`endif

endmodule

@@ src/abhw_outq.sv @@
// result queue taking up to two results per cycle
module abhw_outq import abhw_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  wr_req_t wr_i,
  output logic    ready_o,
  output logic    empty,
  input  logic    pop,
  output result_t head_o
);

  result_t             mem_q [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [OQ_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [OQ_CNT_W-1:0] cnt_q, cnt_d;
  logic                do_rd;

  assign empty   = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_rd   = pop && !empty;
  // room for the worst case of two results from one byte
  assign ready_o = (cnt_q <= OQ_CNT_W'(OQ_DEPTH - 2));

  always_comb begin
    wr_ptr_d = wr_ptr_q + OQ_PTR_W'(wr_i.num);
    rd_ptr_d = do_rd ? rd_ptr_q + OQ_PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + OQ_CNT_W'(wr_i.num) - OQ_CNT_W'(do_rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.num != 2'd0) begin
      mem_q[wr_ptr_q] <= wr_i.r0;
    end
    if (wr_i.num == 2'd2) begin
      mem_q[wr_ptr_q + OQ_PTR_W'(1)] <= wr_i.r1;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_i.num != 2'd0) |-> ((OQ_CNT_W + 1)'(cnt_q) + (OQ_CNT_W + 1)'(wr_i.num)
                            <= (OQ_CNT_W + 1)'(OQ_DEPTH)))
    else $error("result queue written past its depth");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= OQ_CNT_W'(OQ_DEPTH))
    else $error("result queue count out of range");
`endif

endmodule

@@ src/archive_block_header_walker.sv @@
// top level of the archive block header walker
//
// Input channel: one archive byte per transaction on data_byte_i, with
// stream_end_i high on the final byte. A transaction happens at a clock
// edge with push high and full low.
// Result channel: while empty is low the oldest result is on kind_o,
// name_char_o, file_number_o, name_end_o and files_seen_o; it leaves at an
// edge with pop high. kind_o low marks a file name byte, high the file
// count report that follows the final byte.
// Throughput: one byte per cycle while the result queue has room, set by the single-byte parser state
// machine; a final byte that is a name byte yields two results at once.
// The results of a byte pass the input queue register first; the parser
// then writes them into the result queue, whose head drives the result
// ports.
// Reset clears both queues and puts the parser in the marker phase; the
// parser returns to the marker phase on its own after the final byte of an archive.
// When the receiver stops popping, the result queue fills, the parser
// holds and the two-entry input queue raises full.
module archive_block_header_walker import abhw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        stream_end_i,
  output logic        empty,
  input  logic        pop,
  output logic        kind_o,
  output logic [7:0]  name_char_o,
  output logic [15:0] file_number_o,
  output logic        name_end_o,
  output logic [15:0] files_seen_o
);

  item_t   in_item, fq_item;
  logic    fq_valid, fq_ready;
  logic    oq_ready;
  wr_req_t wr_req;
  result_t head;

  assign in_item.data_byte  = data_byte_i;
  assign in_item.stream_end = stream_end_i;

  abhw_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .item_i       (in_item),
    .item_valid_o (fq_valid),
    .item_ready_i (fq_ready),
    .item_o       (fq_item)
  );

  abhw_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (fq_valid),
    .item_ready_o (fq_ready),
    .item_i       (fq_item),
    .oq_ready_i   (oq_ready),
    .wr_o         (wr_req)
  );

  abhw_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr_req),
    .ready_o (oq_ready),
    .empty   (empty),
    .pop     (pop),
    .head_o  (head)
  );

  assign kind_o        = head.kind;
  assign name_char_o   = head.name_char;
  assign file_number_o = head.file_number;
  assign name_end_o    = head.name_end;
  assign files_seen_o  = head.files_seen;

endmodule

@@ bench/abhw_checker.sv @@
// checker for the archive block header walker: byte-level prediction and result comparison
module abhw_checker import abhw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_i,
  input  logic [7:0]  data_byte_i,
  input  logic        stream_end_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  logic        kind_i,
  input  logic [7:0]  name_char_i,
  input  logic [15:0] file_number_i,
  input  logic        name_end_i,
  input  logic [15:0] files_seen_i,
  output int          mismatch_count_o,
  output int          outstanding_o
);

  // walker state as seen from the byte stream
  phase_e           walk_phase;
  logic [CNT_W-1:0] walk_cnt;
  logic [7:0]       blk_type;
  logic [15:0]      blk_size;
  logic [31:0]      packed_len;
  logic [15:0]      name_len;
  logic [15:0]      file_total;

  result_t due_q[$];
  int      errors  = 0;
  int      waiting = 0;

  assign mismatch_count_o = errors;
  assign outstanding_o    = waiting;

  task automatic restart_walk();
    walk_phase = PH_MARKER;
    walk_cnt   = '0;
    blk_type   = '0;
    blk_size   = '0;
    packed_len = '0;
    name_len   = '0;
    file_total = '0;
  endtask

  // saturating skip to the end of the current block
  task automatic leave_block(input logic [CNT_W-1:0] used);
    logic [CNT_W-1:0] stop;
    stop = CNT_W'(blk_size) + CNT_W'(packed_len);
    if (stop > used) begin
      walk_phase = PH_SKIP;
      walk_cnt   = stop - used;
    end else begin
      walk_phase = PH_HEADER;
      walk_cnt   = '0;
    end
  endtask

  task automatic walk_byte(input logic [7:0] b, input logic last);
    result_t r;
    logic    done;
    case (walk_phase)
      PH_MARKER: begin
        walk_cnt++;
        if (walk_cnt >= MARKER_LEN) begin
          walk_phase = PH_HEADER;
          walk_cnt   = '0;
        end
      end
      PH_HEADER: begin
        if (walk_cnt == HDR_TYPE_POS) blk_type = b;
        else if (walk_cnt == HDR_SIZE_LO_POS) blk_size[7:0] = b;
        else if (walk_cnt == HDR_SIZE_HI_POS) blk_size[15:8] = b;
        walk_cnt++;
        if (walk_cnt >= HEADER_LEN) begin
          packed_len = '0;
          name_len   = '0;
          if (blk_type == FILE_BLOCK_TYPE) begin
            if (file_total != 16'hFFFF) file_total++;
            walk_phase = PH_FILEHEAD;
            walk_cnt   = '0;
          end else begin
            leave_block(HEADER_LEN);
          end
        end
      end
      PH_FILEHEAD: begin
        if (walk_cnt < FH_PACKED_END) packed_len[8*walk_cnt[1:0] +: 8] = b;
        else if (walk_cnt == FH_NAME_LO_POS) name_len[7:0] = b;
        else if (walk_cnt == FH_NAME_HI_POS) name_len[15:8] = b;
        walk_cnt++;
        if (walk_cnt >= FILE_HEAD_LEN) begin
          if (name_len == 16'd0) begin
            leave_block(FIXED_LEN);
          end else begin
            walk_phase = PH_NAME;
            walk_cnt   = '0;
          end
        end
      end
      PH_NAME: begin
        walk_cnt++;
        done          = (walk_cnt >= CNT_W'(name_len));
        r.kind        = KIND_NAME;
        r.name_char   = b;
        r.file_number = file_total;
        r.name_end    = done;
        r.files_seen  = file_total;
        due_q.push_back(r);
        if (done) leave_block(FIXED_LEN + CNT_W'(name_len));
      end
      PH_SKIP: begin
        if (walk_cnt != '0) walk_cnt--;
        if (walk_cnt == '0) walk_phase = PH_HEADER;
      end
      default: begin
        walk_phase = PH_HEADER;
        walk_cnt   = '0;
      end
    endcase
    if (last) begin
      r.kind        = KIND_COUNT;
      r.name_char   = '0;
      r.file_number = '0;
      r.name_end    = 1'b0;
      r.files_seen  = file_total;
      due_q.push_back(r);
      restart_walk();
    end
  endtask

  task automatic take_result(input result_t got);
    result_t want;
    if (due_q.size() == 0) begin
      $error("unexpected result: kind %0d name_char %0h file_number %0d files_seen %0d",
             got.kind, got.name_char, got.file_number, got.files_seen);
      errors++;
    end else begin
      want = due_q.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        errors++;
      end
      if (got.name_char !== want.name_char) begin
        $error("name_char: expected %0h, got %0h", want.name_char, got.name_char);
        errors++;
      end
      if (got.file_number !== want.file_number) begin
        $error("file_number: expected %0d, got %0d", want.file_number, got.file_number);
        errors++;
      end
      if (got.name_end !== want.name_end) begin
        $error("name_end: expected %0d, got %0d", want.name_end, got.name_end);
        errors++;
      end
      if (got.files_seen !== want.files_seen) begin
        $error("files_seen: expected %0d, got %0d", want.files_seen, got.files_seen);
        errors++;
      end
    end
  endtask

  initial restart_walk();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_walk();
    end else begin
      if (push_i && !full_i) walk_byte(data_byte_i, stream_end_i);
      if (pop_i && !empty_i) begin
        take_result({kind_i, name_char_i, file_number_i, name_end_i, files_seen_i});
      end
      waiting = due_q.size();
    end
  end

endmodule

@@ bench/tb_top.sv @@
// testbench top for the archive block header walker: archive stimulus and verdict
module tb_top;
  import abhw_pkg::*;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        push        = 1'b0;
  logic [7:0]  data_byte   = 8'h00;
  logic        stream_end  = 1'b0;
  logic        pop         = 1'b0;
  logic        full;
  logic        empty;
  logic        kind;
  logic [7:0]  name_char;
  logic [15:0] file_number;
  logic        name_end;
  logic [15:0] files_seen;
  int          mismatches;
  int          outstanding;

  item_t stream_q[$];
  bit    burst         = 1'b0;
  bit    rx_burst      = 1'b0;
  int    bytes_sent    = 0;
  int    archives      = 0;
  int    results_taken = 0;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  archive_block_header_walker u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .push          (push),
    .full          (full),
    .data_byte_i   (data_byte),
    .stream_end_i  (stream_end),
    .empty         (empty),
    .pop           (pop),
    .kind_o        (kind),
    .name_char_o   (name_char),
    .file_number_o (file_number),
    .name_end_o    (name_end),
    .files_seen_o  (files_seen)
  );

  abhw_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .push_i           (push),
    .full_i           (full),
    .data_byte_i      (data_byte),
    .stream_end_i     (stream_end),
    .empty_i          (empty),
    .pop_i            (pop),
    .kind_i           (kind),
    .name_char_i      (name_char),
    .file_number_i    (file_number),
    .name_end_i       (name_end),
    .files_seen_i     (files_seen),
    .mismatch_count_o (mismatches),
    .outstanding_o    (outstanding)
  );

  task automatic put(input logic [7:0] b);
    item_t it;
    it.data_byte  = b;
    it.stream_end = 1'b0;
    stream_q.push_back(it);
  endtask

  task automatic add_filler(input int n);
    repeat (n) put(8'($urandom));
  endtask

  task automatic add_marker();
    add_filler(7);
  endtask

  // crc, type, flags, size - all little-endian
  task automatic add_header(input logic [7:0] btype, input logic [15:0] hsize);
    add_filler(2);
    put(btype);
    add_filler(2);
    put(hsize[7:0]);
    put(hsize[15:8]);
  endtask

  // skip < 0 means the name was cut short and the archive has to end here
  task automatic add_file(input int nl, input logic [31:0] pk, input int extra,
                          output longint skip);
    int h;
    h = 32 + nl + extra;
    if (h < 0) h = 0;
    if (h > 65535) h = 65535;
    add_header(FILE_BLOCK_TYPE, h[15:0]);
    for (int k = 0; k < 4; k++) put(pk[8*k +: 8]);
    add_filler(15);
    put(nl[7:0]);
    put(nl[15:8]);
    add_filler(4);
    if (nl > 400) begin
      add_filler(8);
      skip = -1;
    end else begin
      add_filler(nl);
      skip = longint'(h) + longint'(pk) - longint'(32 + nl);
      if (skip < 0) skip = 0;
    end
  endtask

  task automatic add_other(input logic [15:0] hsize, output longint skip);
    logic [7:0] t;
    t = 8'($urandom);
    if (t == FILE_BLOCK_TYPE) t = 8'h73;
    add_header(t, hsize);
    skip = (hsize > 16'd7) ? longint'(hsize) - 7 : 0;
  endtask

  task automatic close_archive();
    item_t it;
    it = stream_q.pop_back();
    it.stream_end = 1'b1;
    stream_q.push_back(it);
  endtask

  // push stays high between back-to-back transactions
  task automatic send_all();
    item_t it;
    int    gap;
    while (stream_q.size() > 0) begin
      it  = stream_q.pop_front();
      gap = burst ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      push       <= 1'b1;
      data_byte  <= it.data_byte;
      stream_end <= it.stream_end;
      @(posedge clk);
      while (full) @(posedge clk);
      bytes_sent++;
    end
  endtask

  initial begin : receiver
    int gap;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (results_taken % 40 == 0) rx_burst = ($urandom_range(0, 2) == 0);
      gap = rx_burst ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      results_taken++;
      // long back-pressure so the result and input queues fill up
      if (results_taken == 80) begin
        pop <= 1'b0;
        repeat (400) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    longint     skip;
    int         sel;
    int         pick;
    int         nl;
    int         extra;
    int         h;
    int         cut;
    logic [31:0] pk;
    bit         paused;
    paused = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // final byte right at the start of the marker
    put(8'h00);
    close_archive();
    send_all();
    // stream cut inside the first block header
    repeat (7) put(8'hFF);
    put(8'h00);
    put(8'hFF);
    put(FILE_BLOCK_TYPE);
    close_archive();
    send_all();
    // final byte is also the last name byte: two results at once
    add_marker();
    add_file(1, 32'd0, 0, skip);
    close_archive();
    send_all();
    archives = 3;

    while (bytes_sent < 1000) begin
      stream_q.delete();
      burst = ($urandom_range(0, 3) == 0);
      sel   = $urandom_range(0, 9);
      if (sel == 0) begin
        repeat ($urandom_range(1, 40)) put(8'($urandom));
      end else begin
        add_marker();
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 9) < 6) begin
            pick = $urandom_range(0, 19);
            if (pick < 2) nl = 0;
            else if (pick == 2) nl = $urandom_range(256, 300);
            else if (pick == 3) nl = 65535;
            else nl = $urandom_range(1, 12);
            pick = $urandom_range(0, 19);
            if (pick == 0) pk = 32'hFFFF_FFFF;
            else if (pick == 1) pk = $urandom;
            else pk = $urandom_range(0, 12);
            pick = $urandom_range(0, 9);
            if (pick < 2) extra = -$urandom_range(1, 45);
            else if (pick == 2) extra = 0;
            else extra = $urandom_range(0, 10);
            add_file(nl, pk, extra, skip);
          end else begin
            h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 6) : $urandom_range(7, 24);
            add_other(h[15:0], skip);
          end
          // huge skip or cut name: end the archive inside the block
          if (skip < 0 || skip > 64) begin
            if (skip > 0) add_filler(5);
            break;
          end
          add_filler(int'(skip));
        end
        if (sel == 1) begin
          cut = $urandom_range(1, stream_q.size());
          while (stream_q.size() > cut) void'(stream_q.pop_back());
        end
      end
      close_archive();
      send_all();
      archives++;
      if (!paused && bytes_sent >= 500) begin
        push <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        @(posedge clk);
        paused = 1'b1;
      end
    end

    push <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (8) @(posedge clk);
    $display("walked %0d archives in %0d bytes, %0d results compared",
             archives, bytes_sent, results_taken);
    $display("covered truncated archives, overrun skips, empty and long names and stalls");
    if (mismatches == 0 && outstanding == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin : watchdog
    #40_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
